[design/sppm_pkg.sv]
// Shared types and constants for the sparse polynomial add/sub merge core.
`default_nettype none

package sppm_pkg;

	// Default term capacity of each list
	localparam int DEF_MAX_TERMS = 16;

	// Entries in the command queue between front and back (power of two)
	localparam int QUEUE_DEPTH = 4;

	// Input opcodes
	localparam logic [1:0] OP_APPEND_A = 2'd0;
	localparam logic [1:0] OP_APPEND_B = 2'd1;
	localparam logic [1:0] OP_MERGE    = 2'd2;

	// Classified command kinds
	typedef enum logic [1:0] {
		CMD_APPEND_A = 2'd0,
		CMD_APPEND_B = 2'd1,
		CMD_MERGE    = 2'd2
	} cmd_kind_t;

	// One queued command
	typedef struct packed {
		cmd_kind_t          kind;
		logic signed [15:0] coeff;
		logic signed [15:0] exponent;
	} cmd_t;

	// Back end sequencer states
	typedef enum logic [1:0] {
		ST_IDLE  = 2'b01,
		ST_MERGE = 2'b10
	} back_state_t;

endpackage

`default_nettype wire

[design/sppm_front.sv]
// Front end: accepts input transfers, classifies opcodes and queues commands.
`default_nettype none

module sppm_front
	import sppm_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cmd_valid,
	output logic                    cmd_stall,
	input  wire logic [1:0]         opcode,
	input  wire logic signed [15:0] coeff,
	input  wire logic signed [15:0] exponent,
	output logic                    q_avail,
	output cmd_t                    q_head,
	input  wire logic               q_pop
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	cmd_t             queue_q [QUEUE_DEPTH];
	logic [PTR_W:0]   wr_q;
	logic [PTR_W:0]   rd_q;
	logic             full;
	logic             keep;
	logic             push;
	cmd_kind_t        kind;

	// Classify the opcode; an unused opcode is accepted and dropped
	always_comb begin
		keep = 1'b1;
		kind = CMD_MERGE;
		case (opcode)
			OP_APPEND_A: kind = CMD_APPEND_A;
			OP_APPEND_B: kind = CMD_APPEND_B;
			OP_MERGE:    kind = CMD_MERGE;
			default:     keep = 1'b0;
		endcase
	end

	assign full = (wr_q[PTR_W] != rd_q[PTR_W]) &&
		(wr_q[PTR_W-1:0] == rd_q[PTR_W-1:0]);
	assign cmd_stall = full;
	assign push = cmd_valid && !full && keep;
	assign q_avail = (wr_q != rd_q);
	assign q_head = queue_q[rd_q[PTR_W-1:0]];

	// Advance queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + (PTR_W+1)'(1);
			end
			if (q_pop) begin
				rd_q <= rd_q + (PTR_W+1)'(1);
			end
		end
	end

	// Store the classified command
	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_q[PTR_W-1:0]] <= '{kind: kind, coeff: coeff, exponent: exponent};
		end
	end

endmodule

`default_nettype wire

[design/sppm_back.sv]
// Back end: holds both term lists, runs appends and the two-pointer merge walk.
`default_nettype none

module sppm_back
	import sppm_pkg::*;
#(
	parameter int MAX_TERMS = DEF_MAX_TERMS
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         q_avail,
	input  wire cmd_t         q_head,
	output logic              q_pop,
	output logic              res_valid,
	input  wire logic         res_stall,
	output logic              term_valid,
	output logic signed [15:0] out_exponent,
	output logic signed [16:0] sum_coeff,
	output logic signed [16:0] diff_coeff,
	output logic              overflow,
	output logic              last
);

	localparam int CNT_W = $clog2(MAX_TERMS + 1);
	localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

	logic signed [15:0] a_coeff_q [MAX_TERMS];
	logic signed [15:0] a_exp_q   [MAX_TERMS];
	logic signed [15:0] b_coeff_q [MAX_TERMS];
	logic signed [15:0] b_exp_q   [MAX_TERMS];

	back_state_t        state_q;
	logic [CNT_W-1:0]   cnt_a_q;
	logic [CNT_W-1:0]   cnt_b_q;
	logic [CNT_W-1:0]   i_q;
	logic [CNT_W-1:0]   j_q;
	logic               dropped_q;

	logic               res_valid_q;
	logic               term_valid_q;
	logic signed [15:0] exp_q;
	logic signed [16:0] sum_q;
	logic signed [16:0] diff_q;
	logic               overflow_q;
	logic               last_q;

	logic               a_has;
	logic               b_has;
	logic               a_room;
	logic               b_room;
	logic signed [15:0] ca;
	logic signed [15:0] ea;
	logic signed [15:0] cb;
	logic signed [15:0] eb;
	logic signed [16:0] ca_x;
	logic signed [16:0] cb_x;
	logic [CNT_W-1:0]   i_nxt;
	logic [CNT_W-1:0]   j_nxt;
	logic               w_valid;
	logic signed [15:0] w_exp;
	logic signed [16:0] w_sum;
	logic signed [16:0] w_diff;
	logic               w_last;
	logic               merging;
	logic               out_load;

	assign merging = (state_q == ST_MERGE);
	assign out_load = !res_valid_q || !res_stall;
	assign q_pop = (state_q == ST_IDLE) && q_avail;
	assign a_room = (cnt_a_q < CNT_W'(MAX_TERMS));
	assign b_room = (cnt_b_q < CNT_W'(MAX_TERMS));

	// Read the heads of both lists
	assign a_has = (i_q < cnt_a_q);
	assign b_has = (j_q < cnt_b_q);
	assign ca = a_coeff_q[i_q[IDX_W-1:0]];
	assign ea = a_exp_q[i_q[IDX_W-1:0]];
	assign cb = b_coeff_q[j_q[IDX_W-1:0]];
	assign eb = b_exp_q[j_q[IDX_W-1:0]];
	assign ca_x = {ca[15], ca};
	assign cb_x = {cb[15], cb};

	// Pick the next merged term and advance the pointers
	always_comb begin
		i_nxt = i_q;
		j_nxt = j_q;
		w_valid = 1'b1;
		w_exp = eb;
		w_sum = cb_x;
		w_diff = 17'sd0 - cb_x;
		if (!a_has && !b_has) begin
			w_valid = 1'b0;
			w_exp = '0;
			w_sum = '0;
			w_diff = '0;
		end else if (a_has && b_has && (ea == eb)) begin
			w_exp = ea;
			w_sum = ca_x + cb_x;
			w_diff = ca_x - cb_x;
			i_nxt = i_q + CNT_W'(1);
			j_nxt = j_q + CNT_W'(1);
		end else if (a_has && (!b_has || (ea > eb))) begin
			w_exp = ea;
			w_sum = ca_x;
			w_diff = ca_x;
			i_nxt = i_q + CNT_W'(1);
		end else begin
			j_nxt = j_q + CNT_W'(1);
		end
		w_last = !w_valid || ((i_nxt >= cnt_a_q) && (j_nxt >= cnt_b_q));
	end

	// Sequence appends and merges
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_a_q <= '0;
			cnt_b_q <= '0;
			i_q <= '0;
			j_q <= '0;
			dropped_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (q_avail) begin
						case (q_head.kind)
							CMD_APPEND_A: begin
								if (a_room) begin
									cnt_a_q <= cnt_a_q + CNT_W'(1);
								end else begin
									dropped_q <= 1'b1;
								end
							end
							CMD_APPEND_B: begin
								if (b_room) begin
									cnt_b_q <= cnt_b_q + CNT_W'(1);
								end else begin
									dropped_q <= 1'b1;
								end
							end
							CMD_MERGE: begin
								state_q <= ST_MERGE;
								i_q <= '0;
								j_q <= '0;
							end
							default: ;
						endcase
					end
				end
				ST_MERGE: begin
					if (out_load) begin
						i_q <= i_nxt;
						j_q <= j_nxt;
						if (w_last) begin
							state_q <= ST_IDLE;
							cnt_a_q <= '0;
							cnt_b_q <= '0;
							i_q <= '0;
							j_q <= '0;
							dropped_q <= 1'b0;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Write appended terms into the lists
	always_ff @(posedge clk) begin
		if (q_pop && (q_head.kind == CMD_APPEND_A) && a_room) begin
			a_coeff_q[cnt_a_q[IDX_W-1:0]] <= q_head.coeff;
			a_exp_q[cnt_a_q[IDX_W-1:0]] <= q_head.exponent;
		end
		if (q_pop && (q_head.kind == CMD_APPEND_B) && b_room) begin
			b_coeff_q[cnt_b_q[IDX_W-1:0]] <= q_head.coeff;
			b_exp_q[cnt_b_q[IDX_W-1:0]] <= q_head.exponent;
		end
	end

	// Hold or refill the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_load) begin
			res_valid_q <= merging;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load && merging) begin
			term_valid_q <= w_valid;
			exp_q <= w_exp;
			sum_q <= w_sum;
			diff_q <= w_diff;
			overflow_q <= dropped_q;
			last_q <= w_last;
		end
	end

	assign res_valid = res_valid_q;
	assign term_valid = term_valid_q;
	assign out_exponent = exp_q;
	assign sum_coeff = sum_q;
	assign diff_coeff = diff_q;
	assign overflow = overflow_q;
	assign last = last_q;

endmodule

`default_nettype wire

[design/sparse_polynomial_add_sub_merge_core.sv]
// Top level of the sparse polynomial add/sub merge core.
//
// Commands enter a four-entry queue and are taken one per cycle while it has
// room. An append finishes as it is dequeued. A merge holds the back end
// until its two-pointer walk over the term registers has emitted every result
// term (at most 2*MAX_TERMS, or one item when both lists are empty); commands
// behind it wait in the queue and input stalls once the queue fills. Results
// leave through an output register, so a stall on the result side holds the
// walk without losing a term. Lists must be appended in descending exponent
// order; a merge clears both lists and the overflow flag.
`default_nettype none

module sparse_polynomial_add_sub_merge_core
	import sppm_pkg::*;
#(
	parameter int MAX_TERMS = DEF_MAX_TERMS
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cmd_valid,
	output logic                    cmd_stall,
	input  wire logic [1:0]         opcode,
	input  wire logic signed [15:0] coeff,
	input  wire logic signed [15:0] exponent,
	output logic                    res_valid,
	input  wire logic               res_stall,
	output logic                    term_valid,
	output logic signed [15:0]      out_exponent,
	output logic signed [16:0]      sum_coeff,
	output logic signed [16:0]      diff_coeff,
	output logic                    overflow,
	output logic                    last
);

	logic q_avail;
	logic q_pop;
	cmd_t q_head;

	// Accept and classify commands
	sppm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.opcode    (opcode),
		.coeff     (coeff),
		.exponent  (exponent),
		.q_avail   (q_avail),
		.q_head    (q_head),
		.q_pop     (q_pop)
	);

	// Execute appends and merges
	sppm_back #(
		.MAX_TERMS (MAX_TERMS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_avail      (q_avail),
		.q_head       (q_head),
		.q_pop        (q_pop),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.term_valid   (term_valid),
		.out_exponent (out_exponent),
		.sum_coeff    (sum_coeff),
		.diff_coeff   (diff_coeff),
		.overflow     (overflow),
		.last         (last)
	);

	// An empty merge result is always the final one
	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !term_valid |-> last)
		else $error("empty merge result without last");

	// The back end pops only from a non-empty queue
	a_pop_when_avail: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_avail)
		else $error("pop from empty command queue");

	// After taking a merge the back end does not pop in the following cycle
	a_merge_busy: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop && (q_head.kind == CMD_MERGE) |=> !q_pop)
		else $error("command popped during merge walk");

endmodule

`default_nettype wire
